// ===== rtl/core/pgbs_pkg.sv =====
package pgbs_pkg;

    // Table size default
    localparam int MAX_BODIES_DEF = 64;

    // Tick duration ceiling, 0.1 s in Q0.16
    localparam int DT_W = 13;
    localparam logic [DT_W-1:0] DT_MAX = 13'd6554;

    // Register reset values
    localparam logic [25:0] GRAVITY_RST     = 26'd38076416;
    localparam logic [16:0] RESTITUTION_RST = 17'd52429;
    localparam logic [14:0] AREA_WIDTH_RST  = 15'd1600;
    localparam logic [14:0] AREA_HEIGHT_RST = 15'd900;

    // Register indexes
    localparam logic [1:0] CFG_GRAVITY     = 2'd0;
    localparam logic [1:0] CFG_RESTITUTION = 2'd1;
    localparam logic [1:0] CFG_AREA_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_AREA_HEIGHT = 2'd3;

    // Command actions
    localparam logic [1:0] ACT_TICK       = 2'd0;
    localparam logic [1:0] ACT_ADD_CIRCLE = 2'd1;
    localparam logic [1:0] ACT_ADD_BOX    = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_BODY  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Multiplier operand and product widths
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = 51;
    localparam int RND_W   = PROD_W - 16;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        time_step;
        logic signed [31:0] start_vel_x;
        logic signed [31:0] start_vel_y;
        logic signed [31:0] start_pos_x;
        logic signed [31:0] start_pos_y;
        logic [30:0]        extent_a;
        logic [30:0]        extent_b;
    } cmd_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               accepted;
        logic [5:0]         body_index;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_vel_x;
        logic signed [31:0] out_vel_y;
        logic               last;
    } result_t;

    // One table slot
    typedef struct packed {
        logic               is_box;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [30:0]        extent_a;
        logic [30:0]        extent_b;
    } body_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAV,
        ST_GDT,
        ST_VY,
        ST_PX,
        ST_PY,
        ST_FLOOR,
        ST_FLB,
        ST_RWB,
        ST_LW,
        ST_LWB,
        ST_OUT
    } state_t;

    // Round a Q.16 product to nearest, halves toward +infinity
    function automatic logic signed [RND_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        begin
            q = p + PROD_W'(32768);
            return q[PROD_W-1:16];
        end
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        begin
            if (v > 36'sd2147483647)
                return 32'sh7FFFFFFF;
            else if (v < -36'sd2147483648)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

endpackage

// ===== rtl/core/particle_gravity_bounce_step.sv =====
// Particle table with gravity and wall bounce. An add command stores one body in
// the next free slot, or is refused when the table is full, and answers with a
// single result in the cycle after start; it needs no busy time. A tick walks
// every stored body in slot order through one shared registered multiplier and
// the body memory: set-up states GRAV and GDT, then per body VY, PX, PY, FLOOR,
// FLB, RWB, LW, LWB and OUT, with busy high throughout. Results come one per body
// on result_valid and must be taken in the cycle they appear; the receiver cannot
// stall them. Registers may be written at any time through cfg_valid, which is
// always ready, but take effect cleanly only while busy is low.
module particle_gravity_bounce_step #(
    parameter int MAX_BODIES = pgbs_pkg::MAX_BODIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pgbs_pkg::cmd_t    cmd,
    output pgbs_pkg::result_t result,
    output logic              result_valid,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int CNT_W = $clog2(MAX_BODIES + 1);

    // Control state
    pgbs_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              result_valid_reg;
    pgbs_pkg::result_t result_reg;

    // Registers
    logic [25:0] gravity_reg;
    logic [16:0] restitution_reg;
    logic [14:0] area_width_reg;
    logic [14:0] area_height_reg;

    // Per-body working values
    logic [pgbs_pkg::DT_W-1:0] dt_reg;
    logic [22:0]               gdt_reg;
    logic signed [31:0]        px_reg, py_reg, vx_reg, vy_reg;
    logic                      hit_reg;

    // Body memory
    pgbs_pkg::body_t mem [MAX_BODIES];
    pgbs_pkg::body_t mem_q;
    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    pgbs_pkg::body_t  wr_data;

    // Multiplier
    logic                                mul_en;
    logic signed [pgbs_pkg::MUL_A_W-1:0] mul_a;
    logic        [pgbs_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pgbs_pkg::PROD_W-1:0]  prod;

    logic accept, is_add, is_tick, full, last_body;
    logic [pgbs_pkg::DT_W-1:0] dt_clamped;
    logic [30:0] hx, hy, floor_y, wall_x;
    logic signed [pgbs_pkg::RND_W-1:0] rp, rb;
    logic signed [35:0] vy_sum, px_sum, py_sum, floor_sum, floor_pos;
    logic signed [35:0] wall_sum, wall_pos, left_diff;
    logic signed [31:0] bounced;

    pgbs_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign busy         = (state_reg != pgbs_pkg::ST_IDLE);
    assign accept       = start && !busy;
    assign is_add       = (cmd.action == pgbs_pkg::ACT_ADD_CIRCLE)
                       || (cmd.action == pgbs_pkg::ACT_ADD_BOX);
    assign is_tick      = (cmd.action == pgbs_pkg::ACT_TICK);
    assign full         = (count_reg == CNT_W'(MAX_BODIES));
    assign last_body    = ((CNT_W'(idx_reg) + 1'b1) == count_reg);
    assign dt_clamped   = (cmd.time_step > 16'(pgbs_pkg::DT_MAX))
                        ? pgbs_pkg::DT_MAX : cmd.time_step[pgbs_pkg::DT_W-1:0];
    assign cfg_ready    = 1'b1;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Half extents and walls
    assign hx      = mem_q.is_box ? {1'b0, mem_q.extent_a[30:1]} : mem_q.extent_a;
    assign hy      = mem_q.is_box ? {1'b0, mem_q.extent_b[30:1]} : mem_q.extent_a;
    assign floor_y = {area_height_reg, 16'd0};
    assign wall_x  = {area_width_reg, 16'd0};

    // Sums, wall tests and bounce value
    always_comb
    begin
        rp        = pgbs_pkg::rnd16(prod);
        rb        = pgbs_pkg::rnd16(-prod);
        bounced   = pgbs_pkg::sat32({rb[pgbs_pkg::RND_W-1], rb});
        vy_sum    = {{4{mem_q.vel_y[31]}}, mem_q.vel_y} + {13'd0, gdt_reg};
        px_sum    = {{4{mem_q.pos_x[31]}}, mem_q.pos_x} + {rp[pgbs_pkg::RND_W-1], rp};
        py_sum    = {{4{mem_q.pos_y[31]}}, mem_q.pos_y} + {rp[pgbs_pkg::RND_W-1], rp};
        floor_sum = {5'd0, hy} + {{4{py_reg[31]}}, py_reg};
        floor_pos = {5'd0, floor_y} - {5'd0, hy};
        wall_sum  = {5'd0, hx} + {{4{px_reg[31]}}, px_reg};
        wall_pos  = {5'd0, wall_x} - {5'd0, hx};
        left_diff = {{4{px_reg[31]}}, px_reg} - {5'd0, hx};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pgbs_pkg::ST_IDLE:
            begin
                if (accept && is_tick && (count_reg != '0))
                    state_next = pgbs_pkg::ST_GRAV;
            end
            pgbs_pkg::ST_GRAV:  state_next = pgbs_pkg::ST_GDT;
            pgbs_pkg::ST_GDT:   state_next = pgbs_pkg::ST_VY;
            pgbs_pkg::ST_VY:    state_next = pgbs_pkg::ST_PX;
            pgbs_pkg::ST_PX:    state_next = pgbs_pkg::ST_PY;
            pgbs_pkg::ST_PY:    state_next = pgbs_pkg::ST_FLOOR;
            pgbs_pkg::ST_FLOOR: state_next = pgbs_pkg::ST_FLB;
            pgbs_pkg::ST_FLB:   state_next = pgbs_pkg::ST_RWB;
            pgbs_pkg::ST_RWB:   state_next = pgbs_pkg::ST_LW;
            pgbs_pkg::ST_LW:    state_next = pgbs_pkg::ST_LWB;
            pgbs_pkg::ST_LWB:   state_next = pgbs_pkg::ST_OUT;
            pgbs_pkg::ST_OUT:
            begin
                state_next = last_body ? pgbs_pkg::ST_IDLE : pgbs_pkg::ST_VY;
            end
            default:            state_next = pgbs_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operands and memory ports
    always_comb
    begin
        mul_en  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        wr_en   = 1'b0;
        wr_addr = idx_reg;
        wr_data = '{is_box: mem_q.is_box, pos_x: px_reg, pos_y: py_reg,
                    vel_x: vx_reg, vel_y: vy_reg,
                    extent_a: mem_q.extent_a, extent_b: mem_q.extent_b};
        case (state_reg)
            pgbs_pkg::ST_IDLE:
            begin
                if (accept && is_add && !full)
                begin
                    wr_en   = 1'b1;
                    wr_addr = count_reg[IDX_W-1:0];
                    wr_data = '{is_box: (cmd.action == pgbs_pkg::ACT_ADD_BOX),
                                pos_x: cmd.start_pos_x, pos_y: cmd.start_pos_y,
                                vel_x: cmd.start_vel_x, vel_y: cmd.start_vel_y,
                                extent_a: cmd.extent_a, extent_b: cmd.extent_b};
                end
            end
            pgbs_pkg::ST_GRAV:
            begin
                mul_en = 1'b1;
                mul_a  = {7'd0, gravity_reg};
                mul_b  = {4'd0, dt_reg};
                rd_en  = 1'b1;
            end
            pgbs_pkg::ST_VY:
            begin
                mul_en = 1'b1;
                mul_a  = {mem_q.vel_x[31], mem_q.vel_x};
                mul_b  = {4'd0, dt_reg};
            end
            pgbs_pkg::ST_PX:
            begin
                mul_en = 1'b1;
                mul_a  = {vy_reg[31], vy_reg};
                mul_b  = {4'd0, dt_reg};
            end
            pgbs_pkg::ST_FLOOR:
            begin
                mul_en = 1'b1;
                mul_a  = {vy_reg[31], vy_reg};
                mul_b  = restitution_reg;
            end
            pgbs_pkg::ST_FLB, pgbs_pkg::ST_LW:
            begin
                mul_en = 1'b1;
                mul_a  = {vx_reg[31], vx_reg};
                mul_b  = restitution_reg;
            end
            pgbs_pkg::ST_OUT:
            begin
                wr_en   = 1'b1;
                rd_en   = !last_body;
                rd_addr = idx_reg + 1'b1;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Body memory with a registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q <= mem[rd_addr];
    end

    // Control state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pgbs_pkg::ST_IDLE;
            count_reg        <= '0;
            idx_reg          <= '0;
            result_valid_reg <= 1'b0;
            gravity_reg      <= pgbs_pkg::GRAVITY_RST;
            restitution_reg  <= pgbs_pkg::RESTITUTION_RST;
            area_width_reg   <= pgbs_pkg::AREA_WIDTH_RST;
            area_height_reg  <= pgbs_pkg::AREA_HEIGHT_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pgbs_pkg::CFG_GRAVITY:     gravity_reg     <= cfg_data[25:0];
                    pgbs_pkg::CFG_RESTITUTION: restitution_reg <= cfg_data[16:0];
                    pgbs_pkg::CFG_AREA_WIDTH:  area_width_reg  <= cfg_data[14:0];
                    pgbs_pkg::CFG_AREA_HEIGHT: area_height_reg <= cfg_data[14:0];
                    default:                   gravity_reg     <= gravity_reg;
                endcase
            end
            if (state_reg == pgbs_pkg::ST_IDLE)
            begin
                idx_reg          <= '0;
                result_valid_reg <= accept
                                 && (is_add || (is_tick && (count_reg == '0)));
                if (accept && is_add && !full)
                    count_reg <= count_reg + 1'b1;
            end
            else if (state_reg == pgbs_pkg::ST_OUT)
            begin
                result_valid_reg <= 1'b1;
                idx_reg          <= idx_reg + 1'b1;
            end
            else
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Working values and result beat
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pgbs_pkg::ST_IDLE:
            begin
                dt_reg <= dt_clamped;
                if (accept && is_add)
                begin
                    result_reg <= '{kind: pgbs_pkg::KIND_ADD, accepted: !full,
                                    body_index: full ? 6'd0 : 6'(count_reg[IDX_W-1:0]),
                                    out_pos_x: '0, out_pos_y: '0,
                                    out_vel_x: '0, out_vel_y: '0, last: 1'b1};
                end
                else
                begin
                    result_reg <= '{kind: pgbs_pkg::KIND_EMPTY, accepted: 1'b0,
                                    body_index: 6'd0,
                                    out_pos_x: '0, out_pos_y: '0,
                                    out_vel_x: '0, out_vel_y: '0, last: 1'b1};
                end
            end
            pgbs_pkg::ST_GDT:
            begin
                gdt_reg <= rp[22:0];
            end
            pgbs_pkg::ST_VY:
            begin
                vy_reg <= pgbs_pkg::sat32(vy_sum);
            end
            pgbs_pkg::ST_PX:
            begin
                px_reg <= pgbs_pkg::sat32(px_sum);
            end
            pgbs_pkg::ST_PY:
            begin
                py_reg <= pgbs_pkg::sat32(py_sum);
                vx_reg <= mem_q.vel_x;
            end
            pgbs_pkg::ST_FLOOR:
            begin
                hit_reg <= (floor_sum >= $signed({5'd0, floor_y}));
                if (floor_sum >= $signed({5'd0, floor_y}))
                    py_reg <= pgbs_pkg::sat32(floor_pos);
            end
            pgbs_pkg::ST_FLB:
            begin
                if (hit_reg)
                    vy_reg <= bounced;
                hit_reg <= (wall_sum >= $signed({5'd0, wall_x}));
                if (wall_sum >= $signed({5'd0, wall_x}))
                    px_reg <= pgbs_pkg::sat32(wall_pos);
            end
            pgbs_pkg::ST_RWB, pgbs_pkg::ST_LWB:
            begin
                if (hit_reg)
                    vx_reg <= bounced;
            end
            pgbs_pkg::ST_LW:
            begin
                hit_reg <= (left_diff <= 36'sd0);
                if (left_diff <= 36'sd0)
                    px_reg <= $signed({1'b0, hx});
            end
            pgbs_pkg::ST_OUT:
            begin
                result_reg <= '{kind: pgbs_pkg::KIND_BODY, accepted: 1'b0,
                                body_index: 6'(idx_reg),
                                out_pos_x: px_reg, out_pos_y: py_reg,
                                out_vel_x: vx_reg, out_vel_y: vy_reg,
                                last: last_body};
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // The table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BODIES))
        else $error("body count beyond table depth");

    // A tick only writes back slots that hold a body
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pgbs_pkg::ST_OUT) |-> (CNT_W'(idx_reg) < count_reg))
        else $error("tick reached an empty slot");

    // The last body beat of a tick leaves the block idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.kind == pgbs_pkg::KIND_BODY && result.last) |-> !busy)
        else $error("busy after final body beat");

    // A tick on an empty table answers at once
    a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_tick && count_reg == '0)
        |=> (result_valid && result.kind == pgbs_pkg::KIND_EMPTY && !busy))
        else $error("empty tick not answered");
`endif

endmodule

// ===== rtl/core/pgbs_mul.sv =====
module pgbs_mul (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [pgbs_pkg::MUL_A_W-1:0]  a,
    input  logic        [pgbs_pkg::MUL_B_W-1:0]  b,
    output logic signed [pgbs_pkg::PROD_W-1:0]   prod
);

    logic signed [pgbs_pkg::PROD_W-1:0] prod_reg;

    // Register the signed by unsigned product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * $signed({1'b0, b});
        end
    end

    assign prod = prod_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import pgbs_pkg::*;

    localparam int ONE         = 65536;
    localparam int WMAX        = 2147483647;
    localparam int WMIN        = -2147483647 - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int CHUNK_ITEMS = 34;

    // Action code that the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        cmd_t    c;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        start        = 1'b0;
    cmd_t        cmd          = '0;
    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = CFG_GRAVITY;
    logic [31:0] cfg_data     = '0;
    logic        busy;
    result_t     result;
    logic        result_valid;
    logic        cfg_ready;

    // Shadow of the registers and the body store
    logic [25:0]  grav_q    = GRAVITY_RST;
    logic [16:0]  bounce_q  = RESTITUTION_RST;
    logic [14:0]  wall_px   = AREA_WIDTH_RST;
    logic [14:0]  floor_px  = AREA_HEIGHT_RST;
    body_t        bodies[MAX_BODIES_DEF];
    int unsigned  n_bodies  = 0;

    result_t      fresh_beats[$];
    result_t      reports_due[$];
    bit           typed_pending = 1'b0;
    result_t      typed_want    = '0;
    int unsigned  gap_pct       = 16;

    int unsigned  errors        = 0;
    int unsigned  beats_checked = 0;
    int unsigned  cmds_taken    = 0;
    int unsigned  ticks_run     = 0;
    int unsigned  refusals      = 0;
    int unsigned  reg_writes    = 0;
    int unsigned  idle_cycles   = 0;

    particle_gravity_bounce_step u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result       (result),
        .result_valid (result_valid),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what);
        begin
            $display("ERROR @%0t: %s", $realtime, what);
            errors++;
        end
    endtask

    // Q16.16 product rounding: half steps go up
    function automatic longint round_q16(input longint p);
        begin
            return (p + 32768) >>> 16;
        end
    endfunction

    function automatic longint clamp_word(input longint v);
        begin
            if (v > longint'(WMAX))
                return longint'(WMAX);
            if (v < longint'(WMIN))
                return longint'(WMIN);
            return v;
        end
    endfunction

    function automatic longint rebound(input longint v);
        begin
            return clamp_word(round_q16(-(longint'(bounce_q) * v)));
        end
    endfunction

    // Apply one command to the shadow table and queue the beats it yields
    function automatic void advance_table(input cmd_t c);
        result_t r;
        longint  dt, floor_y, wall_x, hx, hy, px, py, vx, vy;
        begin
            r      = '0;
            r.last = 1'b1;
            if (c.action == ACT_ADD_CIRCLE || c.action == ACT_ADD_BOX) begin
                r.kind = KIND_ADD;
                if (n_bodies < MAX_BODIES_DEF) begin
                    bodies[n_bodies].is_box   = (c.action == ACT_ADD_BOX);
                    bodies[n_bodies].pos_x    = c.start_pos_x;
                    bodies[n_bodies].pos_y    = c.start_pos_y;
                    bodies[n_bodies].vel_x    = c.start_vel_x;
                    bodies[n_bodies].vel_y    = c.start_vel_y;
                    bodies[n_bodies].extent_a = c.extent_a;
                    bodies[n_bodies].extent_b = c.extent_b;
                    r.accepted   = 1'b1;
                    r.body_index = 6'(n_bodies);
                    n_bodies++;
                end
                else
                    refusals++;
                fresh_beats.push_back(r);
            end
            else if (c.action == ACT_TICK) begin
                ticks_run++;
                if (n_bodies == 0) begin
                    r.kind = KIND_EMPTY;
                    fresh_beats.push_back(r);
                end
                else begin
                    dt = longint'(c.time_step);
                    if (dt > longint'(DT_MAX))
                        dt = longint'(DT_MAX);
                    floor_y = longint'(floor_px) * 65536;
                    wall_x  = longint'(wall_px) * 65536;
                    for (int i = 0; i < n_bodies; i++) begin
                        if (bodies[i].is_box) begin
                            hx = longint'(bodies[i].extent_a) / 2;
                            hy = longint'(bodies[i].extent_b) / 2;
                        end
                        else begin
                            hx = longint'(bodies[i].extent_a);
                            hy = hx;
                        end
                        // Velocity first, then position with the new velocity
                        vy = clamp_word(longint'(bodies[i].vel_y)
                                        + round_q16(longint'(grav_q) * dt));
                        vx = longint'(bodies[i].vel_x);
                        px = clamp_word(longint'(bodies[i].pos_x) + round_q16(vx * dt));
                        py = clamp_word(longint'(bodies[i].pos_y) + round_q16(vy * dt));
                        // Floor, right wall, left wall, in that order
                        if (hy + py >= floor_y) begin
                            py = clamp_word(floor_y - hy);
                            vy = rebound(vy);
                        end
                        if (hx + px >= wall_x) begin
                            px = clamp_word(wall_x - hx);
                            vx = rebound(vx);
                        end
                        if (px - hx <= 0) begin
                            px = clamp_word(hx);
                            vx = rebound(vx);
                        end
                        bodies[i].pos_x = 32'(px);
                        bodies[i].pos_y = 32'(py);
                        bodies[i].vel_x = 32'(vx);
                        bodies[i].vel_y = 32'(vy);
                        r            = '0;
                        r.kind       = KIND_BODY;
                        r.body_index = 6'(i);
                        r.out_pos_x  = 32'(px);
                        r.out_pos_y  = 32'(py);
                        r.out_vel_x  = 32'(vx);
                        r.out_vel_y  = 32'(vy);
                        r.last       = (i + 1 == n_bodies);
                        fresh_beats.push_back(r);
                    end
                end
            end
        end
    endfunction

    task automatic compare_beat(input result_t got, input result_t want);
        string tag;
        begin
            tag = $sformatf("beat %0d", beats_checked);
            if (got.kind !== want.kind)
                report_mismatch($sformatf("%s kind got %0d expected %0d",
                                          tag, got.kind, want.kind));
            if (got.accepted !== want.accepted)
                report_mismatch($sformatf("%s accepted got %0d expected %0d",
                                          tag, got.accepted, want.accepted));
            if (got.body_index !== want.body_index)
                report_mismatch($sformatf("%s body_index got %0d expected %0d",
                                          tag, got.body_index, want.body_index));
            if (got.out_pos_x !== want.out_pos_x)
                report_mismatch($sformatf("%s out_pos_x got %0d expected %0d",
                                          tag, got.out_pos_x, want.out_pos_x));
            if (got.out_pos_y !== want.out_pos_y)
                report_mismatch($sformatf("%s out_pos_y got %0d expected %0d",
                                          tag, got.out_pos_y, want.out_pos_y));
            if (got.out_vel_x !== want.out_vel_x)
                report_mismatch($sformatf("%s out_vel_x got %0d expected %0d",
                                          tag, got.out_vel_x, want.out_vel_x));
            if (got.out_vel_y !== want.out_vel_y)
                report_mismatch($sformatf("%s out_vel_y got %0d expected %0d",
                                          tag, got.out_vel_y, want.out_vel_y));
            if (got.last !== want.last)
                report_mismatch($sformatf("%s last got %0d expected %0d",
                                          tag, got.last, want.last));
        end
    endtask

    // Check result beats, track register writes, predict on each taken command
    always @(posedge clk) begin : monitor
        result_t want;
        bit      moved;
        moved = 1'b0;
        if (rst_n === 1'b1) begin
            if (result_valid === 1'b1) begin
                moved = 1'b1;
                if (reports_due.size() == 0)
                    report_mismatch($sformatf("beat %0d arrived with nothing outstanding",
                                              beats_checked));
                else begin
                    want = reports_due.pop_front();
                    compare_beat(result, want);
                end
                beats_checked++;
            end
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_GRAVITY:     grav_q   = cfg_data[25:0];
                    CFG_RESTITUTION: bounce_q = cfg_data[16:0];
                    CFG_AREA_WIDTH:  wall_px  = cfg_data[14:0];
                    CFG_AREA_HEIGHT: floor_px = cfg_data[14:0];
                    default: ;
                endcase
                reg_writes++;
            end
            if (start === 1'b1 && busy === 1'b0) begin
                moved = 1'b1;
                fresh_beats.delete();
                advance_table(cmd);
                if (typed_pending)
                    reports_due.push_back(typed_want);
                else
                    foreach (fresh_beats[k])
                        reports_due.push_back(fresh_beats[k]);
                cmds_taken++;
            end
        end
        idle_cycles <= moved ? 0 : idle_cycles + 1;
    end

    // Abort when nothing has moved for too long
    always @(posedge clk) begin : watchdog
        if (idle_cycles >= STALL_LIMIT) begin
            $display("stalled: nothing moved for %0d cycles", idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Present one command beat, idling first at random, and hold until taken
    task automatic issue(input cmd_t c, input bit typed, input result_t want);
        begin
            @(negedge clk);
            if ($urandom_range(99) < gap_pct) begin
                start = 1'b0;
                do
                    @(negedge clk);
                while ($urandom_range(99) < gap_pct);
            end
            start         = 1'b1;
            cmd           = c;
            typed_pending = typed;
            typed_want    = want;
            @(posedge clk);
            while (busy !== 1'b0)
                @(posedge clk);
        end
    endtask

    // Drop start and wait until every beat is in and the block is idle
    task automatic settle();
        begin
            @(negedge clk);
            start = 1'b0;
            while (reports_due.size() != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
            while (busy !== 1'b0)
                @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        begin
            @(negedge clk);
            cfg_valid = 1'b1;
            cfg_index = idx;
            cfg_data  = val;
            @(posedge clk);
            while (cfg_ready !== 1'b1)
                @(posedge clk);
        end
    endtask

    task automatic load_regs(input logic [31:0] g, input logic [31:0] r,
                             input logic [31:0] w, input logic [31:0] h);
        begin
            write_reg(CFG_GRAVITY, g);
            write_reg(CFG_RESTITUTION, r);
            write_reg(CFG_AREA_WIDTH, w);
            write_reg(CFG_AREA_HEIGHT, h);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    function automatic result_t typed_answer(input logic [1:0] kind, input bit acc,
                                             input int slot);
        result_t r;
        begin
            r            = '0;
            r.kind       = kind;
            r.accepted   = acc;
            r.body_index = 6'(slot);
            r.last       = 1'b1;
            return r;
        end
    endfunction

    function automatic dir_row_t step_row(input logic [1:0] act, input int dt,
                                          input int vx, input int vy,
                                          input int px, input int py,
                                          input int ea, input int eb,
                                          input bit typed, input result_t want);
        dir_row_t row;
        begin
            row.c.action      = act;
            row.c.time_step   = 16'(dt);
            row.c.start_vel_x = 32'(vx);
            row.c.start_vel_y = 32'(vy);
            row.c.start_pos_x = 32'(px);
            row.c.start_pos_y = 32'(py);
            row.c.extent_a    = 31'(ea);
            row.c.extent_b    = 31'(eb);
            row.typed         = typed;
            row.want          = want;
            return row;
        end
    endfunction

    // Mostly plausible bodies and ticks inside the current area, some raw noise
    function automatic cmd_t random_cmd();
        cmd_t        c;
        int unsigned pick;
        begin
            pick          = $urandom_range(99);
            c.action      = 2'($urandom);
            c.time_step   = 16'($urandom);
            c.start_vel_x = 32'($urandom);
            c.start_vel_y = 32'($urandom);
            c.start_pos_x = 32'($urandom);
            c.start_pos_y = 32'($urandom);
            c.extent_a    = 31'($urandom);
            c.extent_b    = 31'($urandom);
            if (pick >= 8) begin
                if (pick < 52)
                    c.action = ACT_TICK;
                else if (pick < 76)
                    c.action = ACT_ADD_CIRCLE;
                else
                    c.action = ACT_ADD_BOX;
                if ($urandom_range(9) != 0)
                    c.time_step = 16'($urandom_range(0, 6554));
                if ($urandom_range(9) != 0) begin
                    c.start_pos_x = int'($urandom_range(0, wall_px)) * ONE
                                    + int'($urandom_range(0, 65535));
                    c.start_pos_y = int'($urandom_range(0, floor_px)) * ONE
                                    + int'($urandom_range(0, 65535));
                    c.start_vel_x = int'($urandom_range(0, 4000)) * ONE - 2000 * ONE;
                    c.start_vel_y = int'($urandom_range(0, 4000)) * ONE - 2000 * ONE;
                    c.extent_a    = 31'($urandom_range(ONE / 4, 60 * ONE));
                    c.extent_b    = 31'($urandom_range(ONE / 4, 60 * ONE));
                end
            end
            return c;
        end
    endfunction

    initial begin : stimulus
        dir_row_t plan[$];
        cmd_t     c;
        int       useful;

        // Directed table: empty tick, ignored action, walls, extremes, dt clamp
        plan.push_back(step_row(ACT_TICK, 6554, 0, 0, 0, 0, 0, 0,
                                1'b1, typed_answer(KIND_EMPTY, 1'b0, 0)));
        plan.push_back(step_row(ACT_UNUSED, 65535, -1, -1, -1, -1, WMAX, WMAX,
                                1'b0, '0));
        plan.push_back(step_row(ACT_ADD_CIRCLE, 0, 100 * ONE, -50 * ONE,
                                800 * ONE, 450 * ONE, 20 * ONE, 0,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 0)));
        plan.push_back(step_row(ACT_ADD_BOX, 0, -30 * ONE, 0,
                                400 * ONE, 300 * ONE, 40 * ONE, 30 * ONE,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 1)));
        plan.push_back(step_row(ACT_ADD_CIRCLE, 0, 0, 500 * ONE,
                                800 * ONE, 895 * ONE, 10 * ONE, 5 * ONE,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 2)));
        plan.push_back(step_row(ACT_ADD_BOX, 0, 800 * ONE, 0,
                                1590 * ONE, 200 * ONE, 40 * ONE, 20 * ONE,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 3)));
        plan.push_back(step_row(ACT_ADD_CIRCLE, 0, -800 * ONE, 0,
                                5 * ONE, 100 * ONE, 8 * ONE, 0,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 4)));
        plan.push_back(step_row(ACT_ADD_CIRCLE, 0, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 5)));
        plan.push_back(step_row(ACT_ADD_BOX, 0, WMIN, WMIN, WMIN, WMIN, WMAX, WMAX,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 6)));
        plan.push_back(step_row(ACT_ADD_BOX, 0, 0, 0, 100 * ONE, 100 * ONE, 3, 1,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 7)));
        plan.push_back(step_row(ACT_ADD_CIRCLE, 0, 0, 0, 0, 0, 0, 0,
                                1'b1, typed_answer(KIND_ADD, 1'b1, 8)));
        plan.push_back(step_row(ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        plan.push_back(step_row(ACT_TICK, 6554, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        plan.push_back(step_row(ACT_TICK, 6555, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        plan.push_back(step_row(ACT_TICK, 65535, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        plan.push_back(step_row(ACT_TICK, 1, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        plan.push_back(step_row(ACT_TICK, 32768, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        plan.push_back(step_row(ACT_UNUSED, 0, 0, 0, 0, 0, 0, 0, 1'b0, '0));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan[k])
            issue(plan[k].c, plan[k].typed, plan[k].want);

        // Random chunks, each after a fresh register load, with the idle rate set per pair of chunks
        for (int chunk = 0; chunk < 6; chunk++) begin
            settle();
            case (chunk)
                0: load_regs(32'(GRAVITY_RST), 32'(RESTITUTION_RST),
                             32'(AREA_WIDTH_RST), 32'(AREA_HEIGHT_RST));
                1: load_regs(32'd0, 32'd65536, 32'd32767, 32'd32767);
                2: load_regs(32'd65536000, 32'd0, 32'd1, 32'd1);
                3: load_regs($urandom_range(0, 65536000), $urandom_range(0, 65536),
                             $urandom_range(200, 2000), $urandom_range(200, 2000));
                4: load_regs(32'hFFFF_FFFF, 32'h0001_FFFF, 32'd0, 32'd0);
                default: load_regs(32'(GRAVITY_RST), 32'(RESTITUTION_RST),
                                   32'(AREA_WIDTH_RST), 32'(AREA_HEIGHT_RST));
            endcase
            gap_pct = (chunk < 2) ? 16 : ((chunk < 4) ? 77 : 0);
            useful  = 0;
            while (useful < CHUNK_ITEMS) begin
                c = random_cmd();
                issue(c, 1'b0, '0);
                if (c.action != ACT_UNUSED)
                    useful++;
            end
        end

        settle();
        repeat (40) @(negedge clk);
        if (reports_due.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived",
                                      reports_due.size()));

        $display("run covered %0d commands: %0d ticks, %0d refused adds, %0d bodies held",
                 cmds_taken, ticks_run, refusals, n_bodies);
        $display("%0d result beats checked across %0d register writes",
                 beats_checked, reg_writes);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
